[rtl/core/laplacian_edge_pixel_counter_top_defines.svh]
// Assertion macros shared by the edge counter RTL.
// Every user of these macros names its clock "clock" and its reset "reset".
`ifndef LAPLACIAN_EDGE_PIXEL_COUNTER_TOP_DEFINES_SVH
`define LAPLACIAN_EDGE_PIXEL_COUNTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define LECNT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);
`define LECNT_ASSERT_NEVER(label, cond, msg) \
   `LECNT_ASSERT(label, !(cond), msg)
`else
`define LECNT_ASSERT(label, prop, msg)
`define LECNT_ASSERT_NEVER(label, cond, msg)
`endif
`endif

[rtl/core/lecnt_pkg.sv]
`default_nettype none
package lecnt_pkg;

   localparam int CFG_W          = 12;
   localparam int PIX_W          = 8;
   localparam int COUNT_W        = 23;
   localparam int RSP_DATA_W     = 24;
   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

   // Filter geometry: a 5x5 window fed by four stored rows.
   localparam int WIN        = 5;
   localparam int LINE_ROWS  = WIN - 1;
   localparam int LINE_W     = LINE_ROWS * PIX_W;
   localparam int EDGE_LEVEL = 255;
   localparam int ROWSUM_W   = $clog2(WIN * 255 + 1);
   localparam int TOTAL_W    = $clog2(WIN * WIN * 255 + 1);

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // Position of a byte within the Y Y Cb Cr group.
   localparam logic [1:0] PHASE_Y0 = 2'd0;
   localparam logic [1:0] PHASE_Y1 = 2'd1;
   localparam logic [1:0] PHASE_CR = 2'd3;

   typedef struct packed {
      logic pix;
      logic calc;
      logic first;
      logic emit;
   } cmd_flags_type;

   function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input int unsigned maxv);
      logic [CFG_W-1:0] r;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (32'(v) > maxv) begin
         r = CFG_W'(maxv);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/core/laplacian_edge_pixel_counter_top.sv]
// Laplacian edge pixel counter.
// The req channel takes a packed frame one byte per transaction in the
// order Y, Y, Cb, Cr; req_tuser high marks the first byte of a frame.
// Chroma is dropped, and a 5x5 Laplacian (24 at the centre, -1 elsewhere)
// runs over the luma plane. Pixels whose clamped response reaches 255 are
// counted, and on the frame's final byte one rsp transaction carries the
// count. Frame size comes from two csr registers, width at index 0 and
// height at index 1; they are to be written only while the block is idle,
// which the block does not enforce. Throughput is one byte per cycle while
// the queue has room. The front end classifies each byte in the cycle it is
// accepted, a four-entry queue decouples it from the back end, and the back
// end runs a line-store read, a window update, two sum stages and the count
// register, which raises rsp_tvalid once the final byte's command leaves s4.
// When the receiver holds rsp_tready low the back end freezes, the queue
// fills and req_tready then falls; no byte or count is lost.
// Reset clears positions, count, window and the registers to 640 x 480.
// The line store holds no reset state and needs no clearing pass.
`default_nettype none
module laplacian_edge_pixel_counter_top import lecnt_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   // Register write port.
   input  logic                  csr_wen,
   input  logic                  csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata,
   // Byte stream in.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIX_W-1:0]      req_tdata,   // [7:0] stream_byte
   input  logic                  req_tuser,   // [0] frame_start
   // Count out.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [22:0] edge_count, [23] zero
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int Q_W   = $bits(cmd_flags_type) + PIX_W + COL_W;

   logic             push, q_full, q_empty, q_pop;
   cmd_flags_type    push_flags, pop_flags;
   logic [PIX_W-1:0] push_pix, pop_pix;
   logic [COL_W-1:0] push_col, pop_col;
   logic [Q_W-1:0]   q_wr_data, q_rd_data;

   lecnt_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push       (push),
      .push_flags (push_flags),
      .push_pix   (push_pix),
      .push_col   (push_col)
   );

   assign q_wr_data = {push_flags, push_pix, push_col};

   lecnt_queue #(
      .DATA_W (Q_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (q_wr_data),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   assign {pop_flags, pop_pix, pop_col} = q_rd_data;

   lecnt_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (!q_empty),
      .q_flags    (pop_flags),
      .q_pix      (pop_pix),
      .q_col      (pop_col),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

[rtl/core/lecnt_front.sv]
`default_nettype none
`include "laplacian_edge_pixel_counter_top_defines.svh"
module lecnt_front import lecnt_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   localparam int COL_W     = $clog2(MAX_WIDTH),
   localparam int ROW_W     = $clog2(MAX_HEIGHT + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wen,
   input  logic                csr_addr,
   input  logic [CFG_W-1:0]    csr_wdata,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [PIX_W-1:0]    req_tdata,
   input  logic                req_tuser,
   input  logic                q_full,
   output logic                push,
   output cmd_flags_type       push_flags,
   output logic [PIX_W-1:0]    push_pix,
   output logic [COL_W-1:0]    push_col
);

   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;
   logic [COL_W-1:0] col_ff, col_in, col_cur, col_nx;
   logic [ROW_W-1:0] row_ff, row_in, row_cur, row_nx;
   logic [1:0]       phase_ff, phase_in, phase_cur, last_phase;
   logic [CFG_W-1:0] w_eff, h_eff;
   logic             take, emit, accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RESET;
         height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_addr))
            CSR_FRAME_WIDTH:  width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      w_eff      = clamp_dim(width_ff, MAX_WIDTH);
      h_eff      = clamp_dim(height_ff, MAX_HEIGHT);
      last_phase = (w_eff[0] & h_eff[0]) ? PHASE_Y1 : PHASE_CR;

      // A frame start restarts the position before this byte is used.
      col_cur   = req_tuser ? '0 : col_ff;
      row_cur   = req_tuser ? '0 : row_ff;
      phase_cur = req_tuser ? PHASE_Y0 : phase_ff;

      take = ((phase_cur == PHASE_Y0) || (phase_cur == PHASE_Y1)) &&
             (32'(row_cur) < 32'(h_eff));

      col_nx = col_cur;
      row_nx = row_cur;
      if (take) begin
         if (32'(col_cur) + 32'd1 >= 32'(w_eff)) begin
            col_nx = '0;
            row_nx = ROW_W'(32'(row_cur) + 32'd1);
         end else begin
            col_nx = COL_W'(32'(col_cur) + 32'd1);
         end
      end

      emit   = (32'(row_nx) >= 32'(h_eff)) && (phase_cur == last_phase);
      accept = req_tvalid && req_tready;

      push             = accept && (take || emit);
      push_flags.pix   = take;
      push_flags.calc  = take && (32'(col_cur) >= 32'(WIN - 1)) &&
                         (32'(row_cur) >= 32'(WIN - 1));
      push_flags.first = take && (col_cur == '0) && (row_cur == '0);
      push_flags.emit  = emit;
      push_pix         = req_tdata;
      push_col         = col_cur;

      col_in   = col_ff;
      row_in   = row_ff;
      phase_in = phase_ff;
      if (accept) begin
         if (emit) begin
            col_in   = '0;
            row_in   = '0;
            phase_in = PHASE_Y0;
         end else begin
            col_in   = col_nx;
            row_in   = row_nx;
            phase_in = phase_cur + 2'd1;
         end
      end
   end

   assign req_tready = !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         phase_ff <= PHASE_Y0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         phase_ff <= phase_in;
      end
   end

   `LECNT_ASSERT(a_emit_restarts, (push && push_flags.emit) |=> (phase_ff == PHASE_Y0 && col_ff == '0 && row_ff == '0), "position not cleared after the count transaction")

endmodule
`default_nettype wire

[rtl/core/lecnt_queue.sv]
`default_nettype none
`include "laplacian_edge_pixel_counter_top_defines.svh"
module lecnt_queue import lecnt_pkg::*; #(
   parameter int DATA_W  = 8,
   parameter int DEPTH   = QUEUE_DEPTH,
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W  = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [DATA_W-1:0] wr_data,
   output logic              full,
   input  logic              rd_en,
   output logic [DATA_W-1:0] rd_data,
   output logic              empty
);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      full    = (count_ff == CNT_W'(DEPTH));
      empty   = (count_ff == '0);
      rd_data = slot_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `LECNT_ASSERT_NEVER(a_q_overflow, wr_en && full, "write into a full queue")
   `LECNT_ASSERT_NEVER(a_q_underflow, rd_en && empty, "read from an empty queue")

endmodule
`default_nettype wire

[rtl/core/lecnt_back.sv]
`default_nettype none
`include "laplacian_edge_pixel_counter_top_defines.svh"
module lecnt_back import lecnt_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   localparam int COL_W    = $clog2(MAX_WIDTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  cmd_flags_type         q_flags,
   input  logic [PIX_W-1:0]      q_pix,
   input  logic [COL_W-1:0]      q_col,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Per column, the luma of the four previous rows, oldest in the low byte.
   logic [LINE_W-1:0] line_mem [MAX_WIDTH];
   logic [LINE_W-1:0] rd_data_ff;
   logic              fwd_hit_ff;
   logic [LINE_W-1:0] fwd_data_ff;

   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   cmd_flags_type     s1_flags_ff, s2_flags_ff, s3_flags_ff, s4_flags_ff;
   logic [PIX_W-1:0]  s1_pix_ff;
   logic [COL_W-1:0]  s1_col_ff;

   logic [PIX_W-1:0]    window_ff [WIN][WIN];
   logic [PIX_W-1:0]    window_in [WIN][WIN];
   logic [ROWSUM_W-1:0] rowsum_ff [WIN];
   logic [ROWSUM_W-1:0] rowsum_in [WIN];
   logic [TOTAL_W-1:0]  center25_ff, center25_in;
   logic [TOTAL_W-1:0]  total;
   logic                s4_hit_ff, hit_in;

   logic [COUNT_W-1:0]  tally_ff, tally_in, tally_sum;
   logic                rsp_valid_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic              adv, rd_en, wr_en;
   logic [LINE_W-1:0] line_in, wr_data;
   logic [PIX_W-1:0]  center;

   always_comb begin
      // The whole pipe moves together unless a finished count is still waiting.
      adv   = !rsp_valid_ff || rsp_tready;
      q_pop = adv && q_valid;
      rd_en = q_pop && q_flags.pix;
      wr_en = adv && s1_valid_ff && s1_flags_ff.pix;

      line_in = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
      wr_data = {s1_pix_ff, line_in[LINE_W-1:PIX_W]};

      for (int i = 0; i < WIN; i++) begin
         for (int j = 0; j < WIN; j++) begin
            if (j < WIN - 1) begin
               window_in[i][j] = window_ff[i][j+1];
            end else if (i < LINE_ROWS) begin
               window_in[i][j] = line_in[i*PIX_W +: PIX_W];
            end else begin
               window_in[i][j] = s1_pix_ff;
            end
         end
      end

      for (int i = 0; i < WIN; i++) begin
         rowsum_in[i] = '0;
         for (int j = 0; j < WIN; j++) begin
            rowsum_in[i] = rowsum_in[i] + ROWSUM_W'(window_ff[i][j]);
         end
      end
      center      = window_ff[WIN/2][WIN/2];
      center25_in = (TOTAL_W'(center) << 4) + (TOTAL_W'(center) << 3) + TOTAL_W'(center);

      total = '0;
      for (int i = 0; i < WIN; i++) begin
         total = total + TOTAL_W'(rowsum_ff[i]);
      end
      // 25*center - total >= 255 is the clamped value reaching full scale.
      hit_in = s3_flags_ff.calc && (center25_ff >= total + TOTAL_W'(EDGE_LEVEL));

      tally_sum = (s4_flags_ff.first ? '0 : tally_ff) + COUNT_W'(s4_hit_ff);
      tally_in  = tally_ff;
      if (adv && s4_valid_ff) begin
         tally_in = s4_flags_ff.emit ? '0 : tally_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[s1_col_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[q_col];
      end
   end

   // A read in the same cycle as a write to the same column sees old data;
   // the written entry is carried along instead.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (adv) begin
         fwd_hit_ff <= rd_en && wr_en && (q_col == s1_col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fwd_data_ff <= wr_data;
         s1_flags_ff <= q_flags;
         s1_pix_ff   <= q_pix;
         s1_col_ff   <= q_col;
         s2_flags_ff <= s1_flags_ff;
         s3_flags_ff <= s2_flags_ff;
         s4_flags_ff <= s3_flags_ff;
         rowsum_ff   <= rowsum_in;
         center25_ff <= center25_in;
         s4_hit_ff   <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN; i++) begin
            for (int j = 0; j < WIN; j++) begin
               window_ff[i][j] <= '0;
            end
         end
      end else if (wr_en) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            s1_valid_ff <= q_pop;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            s4_valid_ff <= s3_valid_ff;
         end
         tally_ff <= tally_in;
         if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (adv && s4_valid_ff && s4_flags_ff.emit) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s4_valid_ff && s4_flags_ff.emit) begin
         rsp_count_ff <= tally_sum;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - COUNT_W){1'b0}}, rsp_count_ff};

   `LECNT_ASSERT(a_emit_loads_rsp, (adv && s4_valid_ff && s4_flags_ff.emit) |=> rsp_valid_ff, "count transaction lost at the output register")
   `LECNT_ASSERT(a_stall_holds_s1, (!adv && s1_valid_ff) |=> (s1_valid_ff && $stable(s1_col_ff)), "stage one moved in a stall")

endmodule
`default_nettype wire
